/* src/capc_pkg.sv */
package capc_pkg;

  localparam int SUBSAMPLES_DEF = 10;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int COORD_W   = 24;  // input coordinate width
  localparam int DIFF_W    = 25;  // signed pixel - centre
  localparam int TERM_W    = 26;  // signed difference plus sub-point offset
  localparam int MAG_W     = 25;  // magnitude of a term
  localparam int SQ_W      = 50;  // square of a term, also sum of two difference squares
  localparam int SUM_W     = 51;  // sx + sy in a cell
  localparam int RAD_W     = 16;
  localparam int THR_W     = 17;  // radius +/- margin
  localparam int THR_SQ_W  = 34;
  localparam int R2_W      = 32;
  localparam int OFF_W     = 13;  // signed sub-point offset, |offset| <= 2^11
  localparam int ROW_CNT_W = 5;   // hits in one row, up to 16
  localparam int ACC_W     = 9;   // hits in the grid, up to 256
  localparam int COUNT_W   = 7;
  localparam int COUNT_MAX = 127;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_ROWS,
    ST_DRAIN,
    ST_DONE
  } capc_state_t;

  // One row travelling along the cell chain
  typedef struct packed {
    logic                 vld;
    logic [SQ_W-1:0]      sq;
    logic [ROW_CNT_W-1:0] cnt;
  } capc_link_t;

  function automatic logic [SQ_W-1:0] sq_mag(input logic signed [TERM_W-1:0] v);
    logic [TERM_W-1:0] neg;
    logic [MAG_W-1:0]  m;
    neg = -v;
    m   = v[TERM_W-1] ? neg[MAG_W-1:0] : v[MAG_W-1:0];
    return m * m;
  endfunction

endpackage

/* src/circular_aperture_pixel_coverage.sv */
// Sequence: each input word passes through the states MUL and CMP; a pixel settled by the distance fast
//   paths then goes straight to DONE, a pixel on the aperture edge goes through ROWS and DRAIN first.
// Throughput: one word at a time; the next input word can be taken in the cycle after the result
//   is loaded, and a result is loaded only once the result register is free or being read.
//   On the edge path one grid row enters the cell chain per cycle, then the chain drains.
// Reset: synchronous, active high; radius clears to 0, the chain and result empty.
module circular_aperture_pixel_coverage #(
  parameter int SUBSAMPLES = capc_pkg::SUBSAMPLES_DEF,
  parameter int FRAC_BITS  = capc_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration: radius register
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [capc_pkg::RAD_W-1:0]       cfg_data,
  // input words
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [capc_pkg::COORD_W-1:0]     centre_x,
  input  logic [capc_pkg::COORD_W-1:0]     centre_y,
  input  logic [capc_pkg::COORD_W-1:0]     pixel_x,
  input  logic [capc_pkg::COORD_W-1:0]     pixel_y,
  // result words
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [capc_pkg::COUNT_W-1:0]     covered_count
);

  localparam int ROW_W    = $clog2(SUBSAMPLES);
  localparam int FULL     = SUBSAMPLES * SUBSAMPLES;
  localparam int FULL_SAT = (FULL > capc_pkg::COUNT_MAX) ? capc_pkg::COUNT_MAX : FULL;
  localparam int MARGIN   = 3 << (FRAC_BITS - 2);  // 0.75 pixel

  capc_pkg::capc_state_t state, state_next;

  logic [capc_pkg::RAD_W-1:0]            radius;
  logic signed [capc_pkg::DIFF_W-1:0]    dx, dy;
  logic [capc_pkg::SQ_W-1:0]             dxsq, dysq, d2;
  logic [capc_pkg::THR_W-1:0]            inner, outer;
  logic [capc_pkg::THR_SQ_W-1:0]         inner2, outer2;
  logic [capc_pkg::R2_W-1:0]             r2;
  logic [ROW_W-1:0]                      row;
  logic [capc_pkg::ACC_W-1:0]            acc;
  logic                                  full_hit, zero_hit, last_row, busy;
  logic                                  in_acc, cell_load, row_issue, out_load;
  logic signed [capc_pkg::TERM_W-1:0]    row_term;

  logic signed [capc_pkg::OFF_W-1:0]     off_tab [SUBSAMPLES];
  capc_pkg::capc_link_t                  links   [SUBSAMPLES+1];
  logic [SUBSAMPLES-1:0]                 vlds;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
    end else if (cfg_valid && cfg_ready) begin
      radius <= cfg_data;
    end
  end

  // ---------------------------------------------------------------- offsets and cells
  // Sub-point k sits at round((k - N/2) * 2^F / N), halves away from zero.
  // Cell k owns column k; rows enter at links[0] and march one cell per cycle.
  genvar k;
  for (k = 0; k < SUBSAMPLES; k++) begin : g_col
    localparam int NUM = (k - SUBSAMPLES / 2) * (1 << FRAC_BITS);
    localparam int MAG = (NUM < 0) ? -NUM : NUM;
    localparam int Q   = (2 * MAG + SUBSAMPLES) / (2 * SUBSAMPLES);
    localparam int OFF = (NUM < 0) ? -Q : Q;

    assign off_tab[k] = capc_pkg::OFF_W'(OFF);

    capc_cell #(
      .OFFSET (OFF)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .load     (cell_load),
      .dx       (dx),
      .r2       (r2),
      .link_in  (links[k]),
      .link_out (links[k+1])
    );

    assign vlds[k] = links[k+1].vld;
  end

  assign busy = links[0].vld || (|vlds);

  // ---------------------------------------------------------------- datapath
  assign in_acc = in_valid && in_ready;

  // stage 1: signed differences
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dx <= $signed({1'b0, pixel_x}) - $signed({1'b0, centre_x});
      dy <= $signed({1'b0, pixel_y}) - $signed({1'b0, centre_y});
    end
  end

  // stage 2: squares of the distance and of the thresholds
  assign inner = (radius > capc_pkg::RAD_W'(MARGIN)) ?
                 capc_pkg::THR_W'(radius) - capc_pkg::THR_W'(MARGIN) : '0;
  assign outer = capc_pkg::THR_W'(radius) + capc_pkg::THR_W'(MARGIN);

  always_ff @(posedge clk) begin
    if (cell_load) begin
      dxsq   <= capc_pkg::sq_mag(capc_pkg::TERM_W'(dx));
      dysq   <= capc_pkg::sq_mag(capc_pkg::TERM_W'(dy));
      inner2 <= inner * inner;
      outer2 <= outer * outer;
      r2     <= radius * radius;
    end
  end

  // stage 3: fast-path decision; the inner test is strict, the outer one lets equality through
  assign d2       = dxsq + dysq;
  assign full_hit = d2 < capc_pkg::SQ_W'(inner2);
  assign zero_hit = d2 > capc_pkg::SQ_W'(outer2);

  // row injection: one squared row term per cycle
  assign last_row = (row == ROW_W'(SUBSAMPLES - 1));
  assign row_term = capc_pkg::TERM_W'(dy) + capc_pkg::TERM_W'(off_tab[row]);

  always_ff @(posedge clk) begin
    if (state == capc_pkg::ST_CMP) begin
      row <= '0;
    end else if (row_issue) begin
      row <= row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      links[0].vld <= 1'b0;
    end else begin
      links[0].vld <= row_issue;
      links[0].sq  <= capc_pkg::sq_mag(row_term);
      links[0].cnt <= '0;
    end
  end

  // grid total, collected from the far end of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (state == capc_pkg::ST_CMP) begin
      acc <= full_hit ? capc_pkg::ACC_W'(FULL) : '0;
    end else if (links[SUBSAMPLES].vld) begin
      acc <= acc + capc_pkg::ACC_W'(links[SUBSAMPLES].cnt);
    end
  end

  // result register: frees the sequencer while a word waits downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      covered_count <= (acc > capc_pkg::ACC_W'(capc_pkg::COUNT_MAX)) ?
                       capc_pkg::COUNT_W'(capc_pkg::COUNT_MAX) : acc[capc_pkg::COUNT_W-1:0];
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= capc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      capc_pkg::ST_IDLE:  if (in_acc) state_next = capc_pkg::ST_MUL;
      capc_pkg::ST_MUL:   state_next = capc_pkg::ST_CMP;
      capc_pkg::ST_CMP: begin
        if (full_hit || zero_hit) begin
          state_next = capc_pkg::ST_DONE;
        end else begin
          state_next = capc_pkg::ST_ROWS;
        end
      end
      capc_pkg::ST_ROWS:  if (last_row) state_next = capc_pkg::ST_DRAIN;
      capc_pkg::ST_DRAIN: if (!busy) state_next = capc_pkg::ST_DONE;
      capc_pkg::ST_DONE:  if (!out_valid || out_ready) state_next = capc_pkg::ST_IDLE;
      default:            state_next = capc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cell_load = 1'b0;
    row_issue = 1'b0;
    out_load  = 1'b0;
    case (state)
      capc_pkg::ST_IDLE:  in_ready  = 1'b1;
      capc_pkg::ST_MUL:   cell_load = 1'b1;
      capc_pkg::ST_CMP:   ;
      capc_pkg::ST_ROWS:  row_issue = 1'b1;
      capc_pkg::ST_DRAIN: ;
      capc_pkg::ST_DONE:  out_load  = !out_valid || out_ready;
      default:            ;
    endcase
  end

  // ---------------------------------------------------------------- checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (covered_count <= capc_pkg::COUNT_W'(FULL_SAT)))
    else $error("covered_count beyond grid size");

  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    acc <= capc_pkg::ACC_W'(FULL))
    else $error("grid total beyond grid size");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == capc_pkg::ST_IDLE) |-> !busy)
    else $error("cell chain busy while idle");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (state == capc_pkg::ST_CMP && zero_hit) |=> (state == capc_pkg::ST_DONE && acc == '0))
    else $error("outside pixel not reported as zero");

endmodule

/* src/capc_cell.sv */
module capc_cell #(
  parameter int OFFSET = 0
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  input  logic signed [capc_pkg::DIFF_W-1:0]     dx,
  input  logic        [capc_pkg::R2_W-1:0]       r2,
  input  capc_pkg::capc_link_t                   link_in,
  output capc_pkg::capc_link_t                   link_out
);

  logic        [capc_pkg::SQ_W-1:0]   sx;
  logic signed [capc_pkg::TERM_W-1:0] term;
  logic        [capc_pkg::SUM_W-1:0]  total;
  logic                               hit;

  // column term of this cell, squared once per word
  assign term = capc_pkg::TERM_W'(dx) + capc_pkg::TERM_W'(OFFSET);

  always_ff @(posedge clk) begin
    if (load) begin
      sx <= capc_pkg::sq_mag(term);
    end
  end

  assign total = capc_pkg::SUM_W'(sx) + capc_pkg::SUM_W'(link_in.sq);
  assign hit   = link_in.vld && (total <= capc_pkg::SUM_W'(r2));

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.vld <= 1'b0;
    end else begin
      link_out.vld <= link_in.vld;
      link_out.sq  <= link_in.sq;
      link_out.cnt <= link_in.cnt + capc_pkg::ROW_CNT_W'(hit);
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

// Testbench for circular_aperture_pixel_coverage.
// Pixels go in on a valid/ready channel. The predictor below counts the grid
// points that fall inside the circle, and each covered_count word is checked
// against the oldest pending pixel. The radius is changed only while the
// block is idle, between test phases.
module tb;

  localparam int SUBSAMPLES = capc_pkg::SUBSAMPLES_DEF;
  localparam int FRAC_BITS  = capc_pkg::FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 4000;     // cycles with no word moving on any channel
  localparam int MAX_SHOWN   = 10;
  localparam logic [capc_pkg::COORD_W-1:0] COORD_MAX = {capc_pkg::COORD_W{1'b1}};
  localparam logic [capc_pkg::COORD_W-1:0] MID       = 24'h100000;

  logic                           clk;
  logic                           rst;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [capc_pkg::RAD_W-1:0]     cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  logic [capc_pkg::COORD_W-1:0]   centre_x;
  logic [capc_pkg::COORD_W-1:0]   centre_y;
  logic [capc_pkg::COORD_W-1:0]   pixel_x;
  logic [capc_pkg::COORD_W-1:0]   pixel_y;
  logic                           out_valid;
  logic                           out_ready;
  logic [capc_pkg::COUNT_W-1:0]   covered_count;

  // one pixel in flight, with what it should produce
  typedef struct {
    logic [capc_pkg::COORD_W-1:0] cx;
    logic [capc_pkg::COORD_W-1:0] cy;
    logic [capc_pkg::COORD_W-1:0] px;
    logic [capc_pkg::COORD_W-1:0] py;
    logic [capc_pkg::RAD_W-1:0]   rad;
    logic [capc_pkg::COUNT_W-1:0] count;
  } coverage_job_t;

  coverage_job_t                pending_pixels[$];
  logic [capc_pkg::RAD_W-1:0]   radius_copy;     // our view of the radius register
  int                           mismatches;
  int                           stall_cycles;
  bit                           no_idle;         // both sides run flat out while set

  circular_aperture_pixel_coverage #(
    .SUBSAMPLES(SUBSAMPLES),
    .FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .centre_x     (centre_x),
    .centre_y     (centre_y),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .covered_count(covered_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Grid count for one pixel. Squares are exact in 64 bits: the largest
  // distance squared is about 2^49.
  function automatic logic [capc_pkg::COUNT_W-1:0] count_covered_points(
    input logic [capc_pkg::COORD_W-1:0] cx,
    input logic [capc_pkg::COORD_W-1:0] cy,
    input logic [capc_pkg::COORD_W-1:0] px,
    input logic [capc_pkg::COORD_W-1:0] py,
    input logic [capc_pkg::RAD_W-1:0]   rad
  );
    longint          dx, dy, num, mag, tx, ty;
    longint          offs[SUBSAMPLES];
    longint unsigned r, margin, inner, outer, r2, d2, sx, sy, hits;
    dx = longint'(px) - longint'(cx);
    dy = longint'(py) - longint'(cy);
    // sub-point offsets, round half away from zero
    for (int k = 0; k < SUBSAMPLES; k++) begin
      num = longint'(k - SUBSAMPLES / 2) * (longint'(1) << FRAC_BITS);
      mag = (num < 0) ? -num : num;
      offs[k] = (2 * mag + SUBSAMPLES) / (2 * SUBSAMPLES);
      if (num < 0) offs[k] = -offs[k];
    end
    r      = rad;
    margin = 3 << (FRAC_BITS - 2);           // 0.75 pixel
    inner  = (r > margin) ? r - margin : 0;
    outer  = r + margin;
    r2     = r * r;
    d2     = dx * dx + dy * dy;
    hits   = 0;
    if (d2 < inner * inner) begin
      hits = SUBSAMPLES * SUBSAMPLES;        // pixel well inside
    end else if (d2 <= outer * outer) begin
      for (int row = 0; row < SUBSAMPLES; row++) begin
        ty = dy + offs[row];
        sy = ty * ty;
        for (int col = 0; col < SUBSAMPLES; col++) begin
          tx = dx + offs[col];
          sx = tx * tx;
          if (sx + sy <= r2) hits++;
        end
      end
    end
    if (hits > capc_pkg::COUNT_MAX) hits = capc_pkg::COUNT_MAX;
    return hits[capc_pkg::COUNT_W-1:0];
  endfunction

  // Result side: random back-pressure, changed on the falling edge.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= no_idle || ($urandom_range(99) >= 9);
    end
  end

  // Everything that moves is seen here at the rising edge: radius writes
  // update our copy, accepted pixels get their prediction queued, and
  // result words are checked against the oldest pending pixel.
  always @(posedge clk) begin
    coverage_job_t job;
    if (!rst) begin
      if (in_valid && in_ready) begin
        job.cx    = centre_x;
        job.cy    = centre_y;
        job.px    = pixel_x;
        job.py    = pixel_y;
        job.rad   = radius_copy;
        job.count = count_covered_points(centre_x, centre_y, pixel_x, pixel_y, radius_copy);
        pending_pixels.push_back(job);
      end
      if (cfg_valid && cfg_ready) radius_copy = cfg_data;
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: covered_count %0d with no pixel pending", $realtime, covered_count);
        end else begin
          job = pending_pixels.pop_front();
          if (covered_count !== job.count) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("%0t: centre (%h,%h) pixel (%h,%h) radius %0d: covered_count exp %0d got %0d",
                       $realtime, job.cx, job.cy, job.px, job.py, job.rad, job.count,
                       covered_count);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  // Hang detector.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no word moved in %0d cycles", STALL_LIMIT);
    $display("** circular_aperture_pixel_coverage: FAILED **");
    $finish;
  end

  // Drive one pixel word and hold it until taken. Idle gaps drop valid
  // first, so valid gets a single assignment per falling edge.
  task automatic send_pixel(
    input logic [capc_pkg::COORD_W-1:0] cx,
    input logic [capc_pkg::COORD_W-1:0] cy,
    input logic [capc_pkg::COORD_W-1:0] px,
    input logic [capc_pkg::COORD_W-1:0] py
  );
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    centre_x <= cx;
    centre_y <= cy;
    pixel_x  <= px;
    pixel_y  <= py;
    do @(posedge clk); while (!in_ready);
  endtask

  // Let every pending pixel come back, then write the radius. Each pixel
  // gives exactly one word, so an empty queue means the block is idle.
  task automatic write_radius(input logic [capc_pkg::RAD_W-1:0] rad);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= rad;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Radius is 0 out of reset: only the grid point at offset zero can hit.
  task automatic test_reset_radius();
    send_pixel('0, '0, '0, '0);
    send_pixel(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_pixel(MID, MID, MID + 24'd1, MID);
  endtask

  // Coordinates at both ends of their range, largest radius.
  task automatic test_coordinate_extremes();
    write_radius({capc_pkg::RAD_W{1'b1}});
    send_pixel('0, '0, COORD_MAX, COORD_MAX);
    send_pixel(COORD_MAX, COORD_MAX, '0, '0);
    send_pixel(COORD_MAX, '0, COORD_MAX, '0);
    send_pixel('0, COORD_MAX, '0, COORD_MAX - 24'd65535);
  endtask

  // Distances on either side of both fast-path thresholds, along +x and -y.
  // The inner test is strict; a distance equal to the outer one goes to the grid.
  task automatic test_fast_path_bounds();
    int inner, outer;
    int steps[4];
    inner = 1000 - 192;
    outer = 1000 + 192;
    steps = '{inner - 1, inner, outer, outer + 1};
    write_radius(16'd1000);
    foreach (steps[i]) send_pixel(MID, MID, MID + capc_pkg::COORD_W'(steps[i]), MID);
    foreach (steps[i]) send_pixel(MID, MID, MID, MID - capc_pkg::COORD_W'(steps[i]));
  endtask

  // Radii 192 (0.75 px), 193 and 1: at or under 0.75 px the inner threshold
  // is zero, so the full-grid shortcut never fires even at zero distance.
  task automatic test_small_radius();
    write_radius(16'd192);
    send_pixel(MID, MID, MID, MID);
    send_pixel(MID, MID, MID + 24'd384, MID);
    send_pixel(MID, MID, MID + 24'd385, MID);
    write_radius(16'd193);
    send_pixel(MID, MID, MID, MID);
    send_pixel(MID, MID, MID, MID + 24'd1);
    write_radius(16'd1);
    send_pixel(MID, MID, MID, MID);
  endtask

  // Random pixels at one radius. Most sit within a pixel or so of the
  // circle edge so the grid gets exercised; some are deep inside, a few
  // are arbitrary coordinates.
  task automatic test_random_pixels(input logic [capc_pkg::RAD_W-1:0] rad, input int n,
                                    input bit calm);
    logic [capc_pkg::COORD_W-1:0] cx, cy, px, py;
    longint                       r, dx, dy, rem;
    int                           pick;
    write_radius(rad);
    no_idle = calm;
    r = rad;
    repeat (n) begin
      pick = $urandom_range(99);
      cx = capc_pkg::COORD_W'($urandom_range(COORD_MAX - 70000, 70000));
      cy = capc_pkg::COORD_W'($urandom_range(COORD_MAX - 70000, 70000));
      if (pick < 75) begin
        dx  = $urandom_range(int'(r) + 384, 0);
        rem = r * r - dx * dx;
        dy  = (rem > 0) ? longint'($rtoi($sqrt(real'(rem)))) : 0;
        dy  = dy + $urandom_range(512, 0) - 256;
      end else if (pick < 90) begin
        dx = $urandom_range(int'(r) / 2 + 1, 0);
        dy = $urandom_range(int'(r) / 2 + 1, 0);
      end else begin
        dx = 0;
        dy = 0;
      end
      if ($urandom_range(1)) dx = -dx;
      if ($urandom_range(1)) dy = -dy;
      if ($urandom_range(1)) begin
        rem = dx;              // swap axes
        dx  = dy;
        dy  = rem;
      end
      px = capc_pkg::COORD_W'(longint'(cx) + dx);
      py = capc_pkg::COORD_W'(longint'(cy) + dy);
      if (pick >= 90) begin
        cx = capc_pkg::COORD_W'($urandom);
        cy = capc_pkg::COORD_W'($urandom);
        px = capc_pkg::COORD_W'($urandom);
        py = capc_pkg::COORD_W'($urandom);
      end
      send_pixel(cx, cy, px, py);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    centre_x    = '0;
    centre_y    = '0;
    pixel_x     = '0;
    pixel_y     = '0;
    radius_copy = '0;
    mismatches  = 0;
    stall_cycles = 0;
    no_idle     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_radius();
    test_coordinate_extremes();
    test_fast_path_bounds();
    test_small_radius();
    test_random_pixels(16'd0, 60, 1'b0);
    test_random_pixels(16'd1, 60, 1'b0);
    test_random_pixels(16'd192, 100, 1'b0);
    test_random_pixels(16'd640, 200, 1'b1);    // long stretch with no idling
    test_random_pixels(capc_pkg::RAD_W'($urandom_range(8191, 256)), 200, 1'b0);
    test_random_pixels({capc_pkg::RAD_W{1'b1}}, 150, 1'b0);
    test_random_pixels(capc_pkg::RAD_W'($urandom_range(65535, 0)), 150, 1'b0);

    // drain, then allow an edge pixel's worth of cycles for stray words
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (2 * SUBSAMPLES + 10) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("** circular_aperture_pixel_coverage: PASSED **");
    end else begin
      $display("** circular_aperture_pixel_coverage: FAILED **");
    end
    $finish;
  end

endmodule
